/* rtl/sfa_pkg.sv */
// shared types, codes and constants for the saturating fixed-point alu
// used by every module of the block; depends on nothing
`default_nettype none

package sfa_pkg;

   // operand and result word as seen on the ports
   localparam int OPERAND_BITS = 32;
   // intermediate width for products and scaled dividends
   localparam int WIDE_BITS = 64;
   // default clamp width of the result
   localparam int WORD_BITS_DEF = 32;
   // fraction bits of the fixed-point format
   localparam int FRAC_BITS = 16;

   // operation codes
   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_SUB = 2'd1;
   localparam logic [1:0] CMD_MUL = 2'd2;
   localparam logic [1:0] CMD_DIV = 2'd3;

   typedef struct packed {
      logic [1:0]                     cmd;
      logic signed [OPERAND_BITS-1:0] operand_a;
      logic signed [OPERAND_BITS-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [OPERAND_BITS-1:0] value;
      logic                           saturated;
      logic                           limit_sticky;
   } rsp_type;

   // one item in flight through the divider stages
   typedef struct packed {
      logic                           direct;     // result already known
      logic signed [OPERAND_BITS-1:0] res_value;
      logic                           res_sat;
      logic                           q_neg;      // quotient sign
      logic [OPERAND_BITS-1:0]        bmag;       // divisor magnitude
      logic [OPERAND_BITS-1:0]        rem;        // partial remainder
      logic [OPERAND_BITS-1:0]        dvd;        // dividend bits still to shift in
      logic [OPERAND_BITS-1:0]        quo;        // quotient bits so far
   } div_work_type;

endpackage

`default_nettype wire

/* rtl/saturating_fixed_point_alu.sv */
// saturating fixed-point alu: add, subtract, multiply and divide on signed words
// fully pipelined; depends on sfa_pkg and sfa_div_stage
//
// usage
//   req channel: req_valid/req_stall with req_data (cmd, operand_a, operand_b);
//   an item transfers at a rising edge with req_valid high and req_stall low
//   rsp channel: rsp_valid/rsp_stall with rsp_data (value, saturated,
//   limit_sticky); exactly one result per item, in order
//   every op passes through the same stages, whatever its cmd
//   throughput: one item per cycle while no stage holds; the divider is one restoring step per
//   stage, WORD_BITS stages, and sets the pipeline length
//   stalls: every stage has its own valid bit and holds only when the stage
//   after it is full and holding, so bubbles close up and new items keep
//   entering while a finished result waits on rsp_stall
//   reset: clears all valid bits and the sticky limit flag; no clearing pass
//   limit_sticky is set by the first saturated result and only reset clears it
`default_nettype none

module saturating_fixed_point_alu #(
   parameter int WORD_BITS = sfa_pkg::WORD_BITS_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire sfa_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output sfa_pkg::rsp_type     rsp_data
);

   localparam int OB = sfa_pkg::OPERAND_BITS;
   localparam int WB = sfa_pkg::WIDE_BITS;
   localparam int FB = sfa_pkg::FRAC_BITS;
   // stages: multiply, prepare, setup, WORD_BITS divide steps, output
   localparam int NSTG = WORD_BITS + 4;
   localparam int OUT_IDX = NSTG - 1;

   // word limits, wide and port width
   localparam logic signed [WB-1:0] WIDE_MAX = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
   localparam logic signed [WB-1:0] WIDE_MIN = -(64'sd1 <<< (WORD_BITS - 1));
   localparam logic signed [OB-1:0] VAL_MAX = WIDE_MAX[OB-1:0];
   localparam logic signed [OB-1:0] VAL_MIN = WIDE_MIN[OB-1:0];
   // quotient magnitudes that reach a limit
   localparam logic [OB-1:0] QMAG_POS = WIDE_MAX[OB-1:0];
   localparam logic [WB-1:0] QMAG_NEG_W = 64'd1 << (WORD_BITS - 1);
   localparam logic [OB-1:0] QMAG_NEG = QMAG_NEG_W[OB-1:0];
   // half an lsb for product rounding
   localparam logic signed [WB-1:0] ROUND_HALF = 64'sd1 <<< (FB - 1);

   typedef struct packed {
      logic [1:0]              cmd;
      logic signed [OB:0]      sum;    // add or subtract, one bit of growth
      logic signed [WB-1:0]    prod;   // full product
      logic signed [WB-1:0]    num;    // scaled dividend with rounding term
      logic signed [OB-1:0]    b;
      logic                    a_pos;
   } s1_type;

   typedef struct packed {
      logic                    is_div;
      logic signed [WB-1:0]    wide;   // add/sub/mul result before clamping
      logic                    b_zero;
      logic                    a_pos;
      logic                    q_neg;
      logic [WB-1:0]           mag;    // dividend magnitude
      logic [OB-1:0]           bmag;
   } s2_type;

   // handshake chain
   logic [NSTG-1:0] vld;
   logic [NSTG:0]   adv;

   logic   s1_vld_ff;
   s1_type s1_ff;
   s1_type s1_in;
   logic   s2_vld_ff;
   s2_type s2_ff;
   s2_type s2_in;

   logic                  div_vld  [WORD_BITS+1];
   sfa_pkg::div_work_type div_work [WORD_BITS+1];
   sfa_pkg::div_work_type s3_in;

   logic             rsp_vld_ff;
   sfa_pkg::rsp_type rsp_data_ff;
   sfa_pkg::rsp_type rsp_data_in;
   logic             sticky_ff;
   logic             sticky_in;

   // a stage takes new content when it is empty or its successor moves
   assign adv[NSTG] = !rsp_stall;
   for (genvar i = 0; i < NSTG; i++) begin : g_adv
      assign adv[i] = !vld[i] || adv[i+1];
   end

   assign vld[0] = s1_vld_ff;
   assign vld[1] = s2_vld_ff;
   for (genvar k = 0; k <= WORD_BITS; k++) begin : g_vld
      assign vld[2+k] = div_vld[k];
   end
   assign vld[OUT_IDX] = rsp_vld_ff;

   assign req_stall = !adv[0];

   // ---------------------------------------------------------------- stage 1
   // sum, product and scaled dividend side by side
   always_comb begin
      logic signed [WB-1:0] a_w;
      logic signed [WB-1:0] b_w;
      a_w         = WB'(req_data.operand_a);
      b_w         = WB'(req_data.operand_b);
      s1_in.cmd   = req_data.cmd;
      s1_in.sum   = (req_data.cmd == sfa_pkg::CMD_SUB)
                    ? (OB+1)'(req_data.operand_a) - (OB+1)'(req_data.operand_b)
                    : (OB+1)'(req_data.operand_a) + (OB+1)'(req_data.operand_b);
      s1_in.prod  = req_data.operand_a * req_data.operand_b;
      s1_in.num   = (a_w <<< FB) + (b_w >>> 1);
      s1_in.b     = req_data.operand_b;
      s1_in.a_pos = !req_data.operand_a[OB-1] && (req_data.operand_a != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv[0]) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------------------------------------------------------- stage 2
   // round the product, take magnitudes for the divider
   always_comb begin
      logic signed [WB-1:0] rounded;
      rounded      = s1_ff.prod + ROUND_HALF;
      s2_in.is_div = (s1_ff.cmd == sfa_pkg::CMD_DIV);
      case (s1_ff.cmd)
         sfa_pkg::CMD_MUL: s2_in.wide = rounded >>> FB;
         default:          s2_in.wide = WB'(s1_ff.sum);
      endcase
      s2_in.b_zero = (s1_ff.b == '0);
      s2_in.a_pos  = s1_ff.a_pos;
      s2_in.q_neg  = s1_ff.num[WB-1] ^ s1_ff.b[OB-1];
      s2_in.mag    = s1_ff.num[WB-1] ? WB'(-s1_ff.num) : WB'(s1_ff.num);
      s2_in.bmag   = s1_ff.b[OB-1] ? OB'(-s1_ff.b) : OB'(s1_ff.b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv[1]) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_ff <= s2_in;
      end
   end

   // ---------------------------------------------------------------- stage 3
   // clamp add/sub/mul, catch divide by zero and quotient overflow,
   // load the long division
   always_comb begin
      logic [WB-1:0] upper;
      upper           = s2_ff.mag >> WORD_BITS;
      s3_in.q_neg     = s2_ff.q_neg;
      s3_in.bmag      = s2_ff.bmag;
      s3_in.rem       = upper[OB-1:0];
      s3_in.dvd       = OB'(s2_ff.mag << (OB - WORD_BITS));
      s3_in.quo       = '0;
      s3_in.direct    = 1'b1;
      s3_in.res_sat   = 1'b0;
      s3_in.res_value = s2_ff.wide[OB-1:0];
      if (!s2_ff.is_div) begin
         if (s2_ff.wide >= WIDE_MAX) begin
            s3_in.res_value = VAL_MAX;
            s3_in.res_sat   = 1'b1;
         end else if (s2_ff.wide <= WIDE_MIN) begin
            s3_in.res_value = VAL_MIN;
            s3_in.res_sat   = 1'b1;
         end
      end else if (s2_ff.b_zero) begin
         // divide by zero goes to max for a positive dividend, else min
         s3_in.res_value = s2_ff.a_pos ? VAL_MAX : VAL_MIN;
         s3_in.res_sat   = 1'b1;
      end else if (upper >= WB'(s2_ff.bmag)) begin
         // quotient needs more than WORD_BITS bits
         s3_in.res_value = s2_ff.q_neg ? VAL_MIN : VAL_MAX;
         s3_in.res_sat   = 1'b1;
      end else begin
         s3_in.direct = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_vld[0] <= 1'b0;
      end else if (adv[2]) begin
         div_vld[0] <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         div_work[0] <= s3_in;
      end
   end

   // ------------------------------------------------------- divider stages
   // one quotient bit per stage, msb first
   for (genvar k = 0; k < WORD_BITS; k++) begin : g_div
      sfa_div_stage u_step (
         .clock    (clock),
         .reset    (reset),
         .load     (adv[3+k]),
         .in_vld   (div_vld[k]),
         .in_work  (div_work[k]),
         .out_vld  (div_vld[k+1]),
         .out_work (div_work[k+1])
      );
   end

   // ---------------------------------------------------------- output stage
   // sign the quotient, clamp it, update the sticky flag
   always_comb begin
      logic [OB-1:0] qmag;
      logic          sat;
      logic signed [OB-1:0] val;
      qmag = div_work[WORD_BITS].quo;
      sat  = 1'b0;
      val  = div_work[WORD_BITS].res_value;
      if (div_work[WORD_BITS].direct) begin
         sat = div_work[WORD_BITS].res_sat;
      end else if (!div_work[WORD_BITS].q_neg) begin
         if (qmag >= QMAG_POS) begin
            val = VAL_MAX;
            sat = 1'b1;
         end else begin
            val = qmag;
         end
      end else begin
         if (qmag >= QMAG_NEG) begin
            val = VAL_MIN;
            sat = 1'b1;
         end else begin
            val = -qmag;
         end
      end
      sticky_in                = sticky_ff | sat;
      rsp_data_in.value        = val;
      rsp_data_in.saturated    = sat;
      rsp_data_in.limit_sticky = sticky_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
         sticky_ff  <= 1'b0;
      end else if (adv[OUT_IDX]) begin
         rsp_vld_ff <= div_vld[WORD_BITS];
         if (div_vld[WORD_BITS]) begin
            sticky_ff <= sticky_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[OUT_IDX]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/sfa_div_stage.sv */
// one restoring division step with its pipeline register
// depends on sfa_pkg for the work item type
`default_nettype none

module sfa_div_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire logic                 in_vld,
   input  wire sfa_pkg::div_work_type in_work,
   output logic                      out_vld,
   output sfa_pkg::div_work_type     out_work
);

   logic                          vld_ff;
   sfa_pkg::div_work_type         work_ff;
   sfa_pkg::div_work_type         work_in;
   logic [sfa_pkg::OPERAND_BITS:0] trial;
   logic [sfa_pkg::OPERAND_BITS:0] diff;
   logic                          fits;

   // bring down the next dividend bit and try the subtract
   always_comb begin
      trial   = {in_work.rem, in_work.dvd[sfa_pkg::OPERAND_BITS-1]};
      diff    = trial - {1'b0, in_work.bmag};
      fits    = (trial >= {1'b0, in_work.bmag});
      work_in = in_work;
      work_in.rem = fits ? diff[sfa_pkg::OPERAND_BITS-1:0]
                         : trial[sfa_pkg::OPERAND_BITS-1:0];
      work_in.dvd = {in_work.dvd[sfa_pkg::OPERAND_BITS-2:0], 1'b0};
      work_in.quo = {in_work.quo[sfa_pkg::OPERAND_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (load) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         work_ff <= work_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_work = work_ff;

endmodule

`default_nettype wire

/* rtl/sfa_checker.sv */
// port-level checks for the saturating fixed-point alu, bound to the top level
// depends on sfa_pkg for the channel types
`default_nettype none

module sfa_checker #(
   parameter int WORD_BITS = sfa_pkg::WORD_BITS_DEF
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire sfa_pkg::rsp_type rsp_data
);

   localparam int OB = sfa_pkg::OPERAND_BITS;
   localparam logic signed [63:0] WIDE_MAX = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] WIDE_MIN = -(64'sd1 <<< (WORD_BITS - 1));
   localparam logic signed [OB-1:0] VAL_MAX = WIDE_MAX[OB-1:0];
   localparam logic signed [OB-1:0] VAL_MIN = WIDE_MIN[OB-1:0];

   logic seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall && rsp_data.limit_sticky) begin
         seen_ff <= 1'b1;
      end
   end

   // once delivered, the sticky flag stays up until reset
   a_sticky_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_ff |-> rsp_data.limit_sticky)
      else $error("limit_sticky dropped without reset");

   // a saturated result always shows in the sticky flag
   a_sat_sets_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |-> rsp_data.limit_sticky)
      else $error("saturated result without limit_sticky");

   // a saturated result sits exactly on a word limit
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         (rsp_data.value == VAL_MAX) || (rsp_data.value == VAL_MIN))
      else $error("saturated value not at a limit");

   // an unsaturated result lies strictly inside the limits
   a_free_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.saturated |->
         (rsp_data.value > VAL_MIN) && (rsp_data.value < VAL_MAX))
      else $error("unsaturated value at or beyond a limit");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind saturating_fixed_point_alu sfa_checker #(.WORD_BITS(WORD_BITS)) u_sfa_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* tb/tb.sv */
// self-checking bench for the saturating fixed-point alu: a directed table, then random traffic
// with random idling on both channels, checked against an in-bench predictor
// depends on sfa_pkg and saturating_fixed_point_alu
`timescale 1ns / 100ps

module tb;

   localparam int HALF_PERIOD = 2;
   localparam int RESET_CYCLES = 10;
   localparam int OPERAND_BITS = sfa_pkg::OPERAND_BITS;
   localparam int FRAC_BITS = sfa_pkg::FRAC_BITS;
   localparam int WORD_BITS = sfa_pkg::WORD_BITS_DEF;
   localparam int RANDOM_ITEMS = 500;
   localparam int PRESSURE_START = 150;   // random item where the long hold-off begins
   localparam int LONG_HOLD = 200;        // cycles the result side holds off
   localparam int DRAIN_CYCLES = WORD_BITS + 30;
   localparam int CYCLE_LIMIT = 300000;
   localparam int PRINT_LIMIT = 100;

   localparam logic signed [OPERAND_BITS-1:0] OPERAND_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [OPERAND_BITS-1:0] OPERAND_MIN = 32'sh8000_0000;
   localparam logic signed [OPERAND_BITS-1:0] ONE_FIX = 32'sh0001_0000;

   // literal expectation that rides along with a directed row
   typedef struct packed {
      logic                           typed;
      logic signed [OPERAND_BITS-1:0] value;
      logic                           sat;
   } typed_expect_type;

   typedef struct {
      sfa_pkg::req_type item;
      typed_expect_type lit;
   } directed_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   sfa_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   sfa_pkg::rsp_type rsp_data;

   typed_expect_type offered_lit = '0;   // tracks the item now on req_data
   sfa_pkg::rsp_type pending_results[$];
   directed_row_type directed_rows[$];
   logic             limit_seen_model = 1'b0;
   bit               pressure_due = 1'b0;
   int unsigned      mismatch_count = 0;
   int unsigned      cycle_count = 0;

   saturating_fixed_point_alu u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // value and per-item flag of one operation; the sticky flag is kept by the scoreboard
   function automatic sfa_pkg::rsp_type fixed_point_result(input sfa_pkg::req_type r);
      longint           a;
      longint           b;
      longint           wide;
      longint           lim_hi;
      longint           lim_lo;
      sfa_pkg::rsp_type res;
      lim_hi = (longint'(1) <<< (WORD_BITS - 1)) - 1;
      lim_lo = -(longint'(1) <<< (WORD_BITS - 1));
      a = r.operand_a;
      b = r.operand_b;
      res = '0;
      case (r.cmd)
         sfa_pkg::CMD_ADD: wide = a + b;
         sfa_pkg::CMD_SUB: wide = a - b;
         // round by adding half an lsb, then floor shift
         sfa_pkg::CMD_MUL: wide = (a * b + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
         default: begin
            // zero divisor lands on a limit, which flags it below
            if (b == 0) wide = (a > 0) ? lim_hi : lim_lo;
            else wide = ((a <<< FRAC_BITS) + (b >>> 1)) / b;
         end
      endcase
      // touching a limit counts as saturating even when nothing was clipped
      if (wide >= lim_hi) begin
         res.value = lim_hi[OPERAND_BITS-1:0];
         res.saturated = 1'b1;
      end else if (wide <= lim_lo) begin
         res.value = lim_lo[OPERAND_BITS-1:0];
         res.saturated = 1'b1;
      end else begin
         res.value = wide[OPERAND_BITS-1:0];
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [OPERAND_BITS-1:0] got,
                                  input logic [OPERAND_BITS-1:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   // scoreboard: predict on every input transfer, compare on every result transfer
   always @(posedge clock) begin : scoreboard
      sfa_pkg::rsp_type want;
      sfa_pkg::rsp_type got;
      if (reset) begin
         limit_seen_model = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            want = fixed_point_result(req_data);
            // directed rows with a literal answer override the predictor
            if (offered_lit.typed) begin
               want.value = offered_lit.value;
               want.saturated = offered_lit.sat;
            end
            limit_seen_model = limit_seen_model | want.saturated;
            want.limit_sticky = limit_seen_model;
            pending_results.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (pending_results.size() == 0) begin
               report_mismatch("result with nothing pending, value", got.value, '0);
            end else begin
               want = pending_results.pop_front();
               if (got.value !== want.value)
                  report_mismatch("value", got.value, want.value);
               if (got.saturated !== want.saturated)
                  report_mismatch("saturated", OPERAND_BITS'(got.saturated),
                                  OPERAND_BITS'(want.saturated));
               if (got.limit_sticky !== want.limit_sticky)
                  report_mismatch("limit_sticky", OPERAND_BITS'(got.limit_sticky),
                                  OPERAND_BITS'(want.limit_sticky));
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side: random stall pattern, plus one long hold-off on request
   initial begin : rsp_side
      int unsigned span;
      logic        hold;
      @(posedge clock);
      forever begin
         if (pressure_due) begin
            // hold long enough that the pipeline fills and pushes back on req
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            pressure_due = 1'b0;
         end else begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
                  hold = 1'b0;
                  span = $urandom_range(1, 8);
               end
               11, 12: begin
                  // quiet stretch with no stalls at all
                  hold = 1'b0;
                  span = $urandom_range(40, 120);
               end
               13, 14, 15, 16, 17, 18: begin
                  hold = 1'b1;
                  span = $urandom_range(1, 3);
               end
               default: begin
                  hold = 1'b1;
                  span = $urandom_range(10, 40);
               end
            endcase
            rsp_stall <= hold;
            repeat (span) @(posedge clock);
         end
      end
   end

   // put one item on req and wait for its transfer; valid only drops when a gap is asked
   task automatic offer(input sfa_pkg::req_type item, input typed_expect_type lit,
                        input int unsigned gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      offered_lit <= lit;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic int unsigned pick_gap(input bit busy);
      if (!busy) return 0;
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: return 0;
         12, 13, 14, 15, 16, 17: return $urandom_range(1, 3);
         default: return $urandom_range(5, 30);
      endcase
   endfunction

   // operand mix: full-range noise, small fixed-point values, powers of two, shifted noise, limits and 0, 1, -1
   function automatic logic signed [OPERAND_BITS-1:0] pick_operand();
      logic signed [OPERAND_BITS-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom;
         4, 5, 6: begin
            v = $urandom_range(0, 32'h7_FFFF);
            v = v - 32'sh4_0000;
         end
         7: begin
            v = 32'sh1 <<< $urandom_range(0, 30);
            if ($urandom_range(0, 1) == 1) v = -v;
         end
         8: begin
            v = $urandom;
            v = v >>> $urandom_range(4, 20);
         end
         default: begin
            case ($urandom_range(0, 4))
               0: v = OPERAND_MAX;
               1: v = OPERAND_MIN;
               2: v = '0;
               3: v = 32'sd1;
               default: v = -32'sd1;
            endcase
         end
      endcase
      return v;
   endfunction

   task automatic add_row(input logic [1:0] cmd, input logic signed [OPERAND_BITS-1:0] a,
                          input logic signed [OPERAND_BITS-1:0] b, input logic typed,
                          input logic signed [OPERAND_BITS-1:0] value, input logic sat);
      directed_row_type row;
      row.item = '{cmd, a, b};
      row.lit = '{typed, value, sat};
      directed_rows.push_back(row);
   endtask

   initial begin : req_side
      sfa_pkg::req_type item;
      bit               busy;
      int               gap;
      // directed table: literal answers where they are obvious, predictor elsewhere
      add_row(sfa_pkg::CMD_ADD, 32'sd0, 32'sd0, 1'b1, 32'sd0, 1'b0);
      add_row(sfa_pkg::CMD_ADD, 32'sh0001_8000, ONE_FIX, 1'b1, 32'sh0002_8000, 1'b0);
      add_row(sfa_pkg::CMD_ADD, OPERAND_MAX, 32'sd1, 1'b1, OPERAND_MAX, 1'b1);
      add_row(sfa_pkg::CMD_ADD, OPERAND_MIN, -32'sd1, 1'b1, OPERAND_MIN, 1'b1);
      // exactly at a limit still flags
      add_row(sfa_pkg::CMD_ADD, OPERAND_MAX, 32'sd0, 1'b1, OPERAND_MAX, 1'b1);
      add_row(sfa_pkg::CMD_SUB, OPERAND_MIN, 32'sd0, 1'b1, OPERAND_MIN, 1'b1);
      add_row(sfa_pkg::CMD_SUB, 32'sd0, OPERAND_MIN, 1'b1, OPERAND_MAX, 1'b1);
      add_row(sfa_pkg::CMD_SUB, OPERAND_MAX, OPERAND_MIN, 1'b1, OPERAND_MAX, 1'b1);
      add_row(sfa_pkg::CMD_SUB, 32'sh0001_0000, 32'sh0003_4000, 1'b0, '0, 1'b0);
      add_row(sfa_pkg::CMD_MUL, ONE_FIX, 32'sh0003_0000, 1'b1, 32'sh0003_0000, 1'b0);
      // rounding at the lsb, both signs
      add_row(sfa_pkg::CMD_MUL, 32'sd1, 32'sd1, 1'b0, '0, 1'b0);
      add_row(sfa_pkg::CMD_MUL, 32'sh0000_8000, 32'sd1, 1'b0, '0, 1'b0);
      add_row(sfa_pkg::CMD_MUL, -32'sd1, 32'sd1, 1'b0, '0, 1'b0);
      add_row(sfa_pkg::CMD_MUL, -32'sd1, -32'sd1, 1'b0, '0, 1'b0);
      add_row(sfa_pkg::CMD_MUL, OPERAND_MIN, OPERAND_MIN, 1'b1, OPERAND_MAX, 1'b1);
      add_row(sfa_pkg::CMD_MUL, OPERAND_MAX, OPERAND_MIN, 1'b1, OPERAND_MIN, 1'b1);
      // zero divisor: max for a positive dividend, min otherwise
      add_row(sfa_pkg::CMD_DIV, 32'sd5, 32'sd0, 1'b1, OPERAND_MAX, 1'b1);
      add_row(sfa_pkg::CMD_DIV, 32'sd0, 32'sd0, 1'b1, OPERAND_MIN, 1'b1);
      add_row(sfa_pkg::CMD_DIV, -32'sd7, 32'sd0, 1'b1, OPERAND_MIN, 1'b1);
      add_row(sfa_pkg::CMD_DIV, ONE_FIX, 32'sh0002_0000, 1'b1, 32'sh0000_8000, 1'b0);
      add_row(sfa_pkg::CMD_DIV, OPERAND_MIN, -32'sd1, 1'b1, OPERAND_MAX, 1'b1);
      add_row(sfa_pkg::CMD_DIV, OPERAND_MAX, 32'sd1, 1'b1, OPERAND_MAX, 1'b1);
      add_row(sfa_pkg::CMD_DIV, 32'sd1, OPERAND_MAX, 1'b0, '0, 1'b0);
      add_row(sfa_pkg::CMD_DIV, -32'sh0003_0000, ONE_FIX, 1'b0, '0, 1'b0);
      // negative divisor: floor shift of the rounding term, truncating quotient
      add_row(sfa_pkg::CMD_DIV, 32'sd3, -32'sd2, 1'b0, '0, 1'b0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         offer(directed_rows[i].item, directed_rows[i].lit, pick_gap(1'b1));

      busy = 1'b1;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // switch between idling and back-to-back traffic now and then
         if (i % 60 == 0) busy = ($urandom_range(0, 3) != 0);
         if (i == PRESSURE_START) pressure_due = 1'b1;
         item.cmd = 2'($urandom_range(0, 3));
         item.operand_a = pick_operand();
         item.operand_b = pick_operand();
         if (item.cmd == sfa_pkg::CMD_DIV && $urandom_range(0, 15) == 0) item.operand_b = '0;
         // keep offering back to back until the long hold-off is over
         if (pressure_due) gap = 0;
         else gap = pick_gap(busy);
         offer(item, '0, gap);
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      // let any stray late result show up before deciding
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
